// ----- src/focctl_pkg.sv -----
// Shared definitions for the open-loop FOC current controller.
// Holds divider widths, the divider status word, register indexes and the sine table generator.
// No dependencies.
package focctl_pkg;

  // Default size of the sine table, as a power of two.
  localparam int unsigned SINE_TABLE_BITS = 8;

  // Shared restoring divider: dividend, divisor and quotient widths.
  localparam int unsigned DIV_NUM_W = 52;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_QUO_W = 17;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_D_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_TARGET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd7;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

  // Quarter-wave sine, x in 0..16384, Q15 result (ninth-order odd polynomial).
  function automatic longint quarter_sine(input longint x);
    longint z;
    longint z2;
    longint p;
    longint r;
    z  = x <<< 16;
    z2 = (z * z) >>> 30;
    p  = 172272;
    p  = 5026995 - ((p * z2) >>> 30);
    p  = 85569306 - ((p * z2) >>> 30);
    p  = 693598670 - ((p * z2) >>> 30);
    p  = 1686629713 - ((p * z2) >>> 30);
    r  = (((p * z) >>> 30) + 16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return r;
  endfunction

  // Sine table entry for a given index, evaluated at elaboration.
  function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                    input int unsigned bits);
    longint a;
    longint q;
    longint x;
    longint r;
    a = longint'(idx << (16 - bits)) & 64'hFFFF;
    q = a >>> 14;
    x = a & 64'h3FFF;
    if ((q & 1) != 0) begin
      x = 16384 - x;
    end
    r = quarter_sine(x);
    if ((q & 2) != 0) begin
      r = -r;
    end
    return r[15:0];
  endfunction

endpackage

// ----- src/focctl_div.sv -----
// Restoring divider used by the duty computation.
// One quotient bit per cycle, with an overflow flag when the quotient does not fit.
// Depends on focctl_pkg.
module focctl_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [focctl_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [focctl_pkg::DIV_DEN_W-1:0]    den_i,
  output logic [focctl_pkg::DIV_QUO_W-1:0]    quot_o,
  output focctl_pkg::div_status_t             status_o
);
  import focctl_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_QUO_W + 1);
  localparam int unsigned DshW = DIV_DEN_W + DIV_QUO_W - 1;

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] rem_q, rem_d;
  logic [DshW-1:0]      dsh_q, dsh_d;
  logic [DIV_QUO_W-1:0] quot_q, quot_d;
  logic                 ovf_q, ovf_d;
  logic                 geq;

  // Trial subtraction of the shifted divisor.
  assign geq = rem_q >= DIV_NUM_W'(dsh_q);

  // Next-state logic for one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DIV_QUO_W);
      rem_d  = num_i;
      dsh_d  = {den_i, {(DIV_QUO_W-1){1'b0}}};
      quot_d = '0;
      ovf_d  = num_i >= DIV_NUM_W'({den_i, {DIV_QUO_W{1'b0}}});
    end else if (busy_q && (cnt_q != '0)) begin
      if (geq) begin
        rem_d = rem_q - DIV_NUM_W'(dsh_q);
      end
      quot_d = {quot_q[DIV_QUO_W-2:0], geq};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - CntW'(1);
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign quot_o          = quot_q;
  assign status_o.done   = busy_q && (cnt_q == '0);
  assign status_o.ovf    = ovf_q;

endmodule

// ----- src/foc_open_loop_current_controller.sv -----
// Each accepted word is worked through the sequencer to one result; a positive duty takes
// a pass of the shared divider, and a duty clamped to zero skips the divider.
// The next word is taken on the cycle after the result is loaded, even while that result
// waits on the output; no new word is taken before the result is loaded.
// Reset (asynchronous, active low) restores the register defaults, clears both integrators
// and the angle; no clearing pass is needed. Depends on focctl_pkg and focctl_div.
module foc_open_loop_current_controller #(
  parameter int unsigned SineTableBits = focctl_pkg::SINE_TABLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // phase_a_code[11:0], phase_b_code[23:12], bus_voltage[38:24], zero pad [39]
  input  logic [39:0]                          s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // duty_a[15:0], duty_b[31:16], duty_c[47:32], current_d[63:48], current_q[79:64],
  // voltage_d[95:80], voltage_q[111:96], angle_used[127:112]
  output logic [127:0]                         m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [focctl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [focctl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import focctl_pkg::*;

  localparam int unsigned SineDepth  = 2 ** SineTableBits;
  localparam int unsigned QuarterIdx = 2 ** (SineTableBits - 2);

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SIN   = 5'd1;
  localparam logic [4:0] S_COS   = 5'd2;
  localparam logic [4:0] S_IA    = 5'd3;
  localparam logic [4:0] S_BETA  = 5'd7;
  localparam logic [4:0] S_PARK0 = 5'd8;
  localparam logic [4:0] S_PARK1 = 5'd9;
  localparam logic [4:0] S_PARK2 = 5'd10;
  localparam logic [4:0] S_PARK3 = 5'd11;
  localparam logic [4:0] S_PARK4 = 5'd12;
  localparam logic [4:0] S_PID0  = 5'd13;
  localparam logic [4:0] S_PID1  = 5'd14;
  localparam logic [4:0] S_PIQ0  = 5'd15;
  localparam logic [4:0] S_PIQ1  = 5'd16;
  localparam logic [4:0] S_IP0   = 5'd17;
  localparam logic [4:0] S_IP1   = 5'd18;
  localparam logic [4:0] S_IP2   = 5'd19;
  localparam logic [4:0] S_IP3   = 5'd20;
  localparam logic [4:0] S_IP4   = 5'd21;
  localparam logic [4:0] S_SV0   = 5'd22;
  localparam logic [4:0] S_SV1   = 5'd23;
  localparam logic [4:0] S_DM    = 5'd24;
  localparam logic [4:0] S_DD    = 5'd25;
  localparam logic [4:0] S_DW    = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;

  // Rounded arithmetic shift, halves towards plus infinity.
  function automatic logic signed [63:0] rsh_round(input logic signed [63:0] x,
                                                   input int unsigned s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Saturate to the signed 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      return 16'sh7FFF;
    end
    if (x < -64'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  // ADC code to current in 1/1024 A: code * 20480 / 4095 rounded half up, less 10240.
  // Since 20480 = 5 * 4095 + 5, this is 5 * code plus the whole 4095s in 5 * code + 2047.
  function automatic logic signed [15:0] code_to_amps(input logic [11:0] code);
    logic [14:0] five;
    logic [14:0] rem;
    logic [2:0]  whole;
    five  = {1'b0, code, 2'b0} + {3'b0, code};
    rem   = five + 15'd2047;
    whole = {2'b0, rem >= 15'd4095} + {2'b0, rem >= 15'd8190} + {2'b0, rem >= 15'd12285}
          + {2'b0, rem >= 15'd16380} + {2'b0, rem >= 15'd20475};
    return $signed({1'b0, five}) + $signed({13'b0, whole}) - 16'sd10240;
  endfunction

  // Clamp the integrator to +-(limit * 256).
  function automatic logic signed [31:0] clamp_int(input logic signed [63:0] x,
                                                   input logic [22:0] lim);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed({33'b0, lim, 8'b0});
    lo = -hi;
    if (x > hi) begin
      return hi[31:0];
    end
    if (x < lo) begin
      return lo[31:0];
    end
    return x[31:0];
  endfunction

  // Clamp a voltage command to +-drive limit.
  function automatic logic signed [15:0] clamp_drive(input logic signed [63:0] x,
                                                     input logic [14:0] lim);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed({49'b0, lim});
    lo = -hi;
    if (x > hi) begin
      return hi[15:0];
    end
    if (x < lo) begin
      return lo[15:0];
    end
    return x[15:0];
  endfunction

  // Configuration registers.
  logic signed [15:0] dtgt_q, qtgt_q, step_q;
  logic [15:0]        prop_q, per_q;
  logic [23:0]        igain_q;
  logic [22:0]        ilim_q;
  logic [14:0]        dlim_q;

  // Sequencer and datapath registers.
  logic [4:0]         state_q, state_d;
  logic [11:0]        ca_q, ca_d, cb_q, cb_d;
  logic [14:0]        vdc_q, vdc_d;
  logic [15:0]        theta_q, theta_d, angle_q, angle_d;
  logic signed [15:0] s_q, s_d, c_q, c_d;
  logic signed [15:0] ia_q, ia_d, ib_q, ib_d, beta_q, beta_d;
  logic signed [15:0] id_q, id_d, iq_q, iq_d, vd_q, vd_d, vq_q, vq_d;
  logic signed [63:0] acc_q, acc_d, prod_q;
  logic signed [31:0] dint_q, dint_d, qint_q, qint_d;
  logic signed [17:0] va_q, va_d, vb_q, vb_d;
  logic signed [35:0] pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic signed [36:0] mm_q, mm_d;
  logic [1:0]         ph_q, ph_d;
  logic [15:0]        duty_q [3];
  logic [15:0]        duty_d [3];
  logic [127:0]       out_q, out_d;
  logic               mvalid_q, mvalid_d;

  // Shared multiplier operands.
  logic signed [37:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [63:0] mul_p;

  // Sine table and its registered read port.
  logic signed [15:0]        sine_rom [SineDepth];
  logic [SineTableBits-1:0]  rom_addr, sin_idx, cos_idx;
  logic signed [15:0]        rom_q;

  // Divider connection.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_QUO_W-1:0] div_quot;
  div_status_t          div_st;

  // Helper values.
  logic signed [37:0] err_d_axis, err_q_axis, inner;
  logic signed [35:0] p_sel, mx, mn;
  logic signed [63:0] t64;

  for (genvar g = 0; g < SineDepth; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SineTableBits);
  end

  assign sin_idx = theta_q[15 -: SineTableBits];
  assign cos_idx = sin_idx + QuarterIdx[SineTableBits-1:0];

  always_ff @(posedge clk_i) begin
    rom_q <= sine_rom[rom_addr];
  end

  // One registered multiply per cycle.
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  assign err_d_axis = 38'(dtgt_q) - 38'(id_q);
  assign err_q_axis = 38'(qtgt_q) - 38'(iq_q);

  // Phase voltage selected for the current duty, and min-max offset terms.
  always_comb begin
    case (ph_q)
      2'd0:    p_sel = pa_q;
      2'd1:    p_sel = pb_q;
      default: p_sel = pc_q;
    endcase
    mx = (pa_q > pb_q) ? pa_q : pb_q;
    if (pc_q > mx) begin
      mx = pc_q;
    end
    mn = (pa_q < pb_q) ? pa_q : pb_q;
    if (pc_q < mn) begin
      mn = pc_q;
    end
  end

  assign inner = $signed({7'b0, vdc_q, 16'b0}) + $signed({p_sel[35], p_sel, 1'b0})
               - $signed({mm_q[36], mm_q});

  // Divider operands: duty numerator over 2^17 times the bus voltage.
  assign div_num = prod_q[DIV_NUM_W-1:0];
  assign div_den = {vdc_q, 17'b0};

  focctl_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .quot_o   (div_quot),
    .status_o (div_st)
  );

  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer: most states consume the last product, issue the next multiply, or both.
  always_comb begin
    state_d   = state_q;
    ca_d      = ca_q;
    cb_d      = cb_q;
    vdc_d     = vdc_q;
    theta_d   = theta_q;
    angle_d   = angle_q;
    s_d       = s_q;
    c_d       = c_q;
    ia_d      = ia_q;
    ib_d      = ib_q;
    beta_d    = beta_q;
    id_d      = id_q;
    iq_d      = iq_q;
    vd_d      = vd_q;
    vq_d      = vq_q;
    acc_d     = acc_q;
    dint_d    = dint_q;
    qint_d    = qint_q;
    va_d      = va_q;
    vb_d      = vb_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    pc_d      = pc_q;
    mm_d      = mm_q;
    ph_d      = ph_q;
    duty_d    = duty_q;
    out_d     = out_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    mul_a     = '0;
    mul_b     = '0;
    rom_addr  = sin_idx;
    div_start = 1'b0;
    t64       = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ca_d    = s_axis_tdata[11:0];
          cb_d    = s_axis_tdata[23:12];
          vdc_d   = (s_axis_tdata[38:24] == '0) ? 15'd1 : s_axis_tdata[38:24];
          theta_d = angle_q;
          state_d = S_SIN;
        end
      end
      S_SIN: begin
        state_d = S_COS;
      end
      S_COS: begin
        rom_addr = cos_idx;
        s_d      = rom_q;
        state_d  = S_IA;
      end
      // Cosine arrives; both phase currents are scaled in the same cycle.
      S_IA: begin
        c_d     = rom_q;
        ia_d    = code_to_amps(ca_q);
        ib_d    = code_to_amps(cb_q);
        state_d = S_BETA;
      end
      // Clarke: beta = (ia + 2 ib) * 37837 / 2^16.
      S_BETA: begin
        mul_a   = 38'(ia_q) + (38'(ib_q) <<< 1);
        mul_b   = 26'sd37837;
        state_d = S_PARK0;
      end
      // Park transform.
      S_PARK0: begin
        t64     = rsh_round(prod_q, 16);
        beta_d  = t64[15:0];
        mul_a   = 38'(ia_q);
        mul_b   = 26'(c_q);
        state_d = S_PARK1;
      end
      S_PARK1: begin
        acc_d   = prod_q;
        mul_a   = 38'(beta_q);
        mul_b   = 26'(s_q);
        state_d = S_PARK2;
      end
      S_PARK2: begin
        id_d    = sat16(rsh_round(acc_q + prod_q, 15));
        mul_a   = 38'(ia_q);
        mul_b   = 26'(s_q);
        state_d = S_PARK3;
      end
      S_PARK3: begin
        acc_d   = prod_q;
        mul_a   = 38'(beta_q);
        mul_b   = 26'(c_q);
        state_d = S_PARK4;
      end
      S_PARK4: begin
        iq_d    = sat16(rsh_round(prod_q - acc_q, 15));
        mul_a   = err_d_axis;
        mul_b   = $signed({2'b0, igain_q});
        state_d = S_PID0;
      end
      // PI regulators, d axis then q axis.
      S_PID0: begin
        dint_d  = clamp_int(64'(dint_q) + rsh_round(prod_q, 13), ilim_q);
        mul_a   = err_d_axis;
        mul_b   = $signed({10'b0, prop_q});
        state_d = S_PID1;
      end
      S_PID1: begin
        vd_d    = clamp_drive(rsh_round(prod_q + (64'(dint_q) <<< 1), 9), dlim_q);
        mul_a   = err_q_axis;
        mul_b   = $signed({2'b0, igain_q});
        state_d = S_PIQ0;
      end
      S_PIQ0: begin
        qint_d  = clamp_int(64'(qint_q) + rsh_round(prod_q, 13), ilim_q);
        mul_a   = err_q_axis;
        mul_b   = $signed({10'b0, prop_q});
        state_d = S_PIQ1;
      end
      S_PIQ1: begin
        vq_d    = clamp_drive(rsh_round(prod_q + (64'(qint_q) <<< 1), 9), dlim_q);
        mul_a   = 38'(vd_q);
        mul_b   = 26'(c_q);
        state_d = S_IP0;
      end
      // Inverse Park transform.
      S_IP0: begin
        acc_d   = prod_q;
        mul_a   = 38'(vq_q);
        mul_b   = 26'(s_q);
        state_d = S_IP1;
      end
      S_IP1: begin
        t64     = rsh_round(acc_q - prod_q, 15);
        va_d    = t64[17:0];
        mul_a   = 38'(vd_q);
        mul_b   = 26'(s_q);
        state_d = S_IP2;
      end
      S_IP2: begin
        acc_d   = prod_q;
        mul_a   = 38'(vq_q);
        mul_b   = 26'(c_q);
        state_d = S_IP3;
      end
      S_IP3: begin
        t64     = rsh_round(acc_q + prod_q, 15);
        vb_d    = t64[17:0];
        state_d = S_IP4;
      end
      S_IP4: begin
        mul_a   = 38'(vb_q);
        mul_b   = 26'sd56756;
        state_d = S_SV0;
      end
      // Phase voltages scaled by 2^16.
      S_SV0: begin
        pa_d    = 36'(va_q) <<< 16;
        pb_d    = -(36'(va_q) <<< 15) + $signed(prod_q[35:0]);
        pc_d    = -(36'(va_q) <<< 15) - $signed(prod_q[35:0]);
        ph_d    = 2'd0;
        state_d = S_SV1;
      end
      S_SV1: begin
        mm_d    = 37'(mx) + 37'(mn);
        state_d = S_DM;
      end
      // Duty numerator: period * (2^16 vdc + 2 v - (max + min)).
      S_DM: begin
        mul_a   = inner;
        mul_b   = $signed({10'b0, per_q});
        state_d = S_DD;
      end
      S_DD: begin
        if (prod_q[63] || (prod_q == '0)) begin
          duty_d[ph_q] = '0;
          ph_d         = ph_q + 2'd1;
          state_d      = (ph_q == 2'd2) ? S_OUT : S_DM;
        end else begin
          div_start = 1'b1;
          state_d   = S_DW;
        end
      end
      S_DW: begin
        if (div_st.done) begin
          if (div_st.ovf || (div_quot > {1'b0, per_q})) begin
            duty_d[ph_q] = per_q;
          end else begin
            duty_d[ph_q] = div_quot[15:0];
          end
          ph_d    = ph_q + 2'd1;
          state_d = (ph_q == 2'd2) ? S_OUT : S_DM;
        end
      end
      // Load the output register once it is free, then advance the angle.
      S_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          out_d    = {theta_q, vq_q, vd_q, iq_q, id_q, duty_q[2], duty_q[1], duty_q[0]};
          mvalid_d = 1'b1;
          angle_d  = theta_q + step_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, integrators and angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mvalid_q <= 1'b0;
      angle_q  <= '0;
      dint_q   <= '0;
      qint_q   <= '0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
      angle_q  <= angle_d;
      dint_q   <= dint_d;
      qint_q   <= qint_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtgt_q  <= 16'sd0;
      qtgt_q  <= 16'sd512;
      prop_q  <= 16'd128;
      igain_q <= 24'd2621;
      ilim_q  <= 23'd256000;
      dlim_q  <= 15'd6144;
      step_q  <= 16'sd5;
      per_q   <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_D_TARGET:   dtgt_q  <= cfg_wdata_i[15:0];
        REG_Q_TARGET:   qtgt_q  <= cfg_wdata_i[15:0];
        REG_PROP_GAIN:  prop_q  <= cfg_wdata_i[15:0];
        REG_INTEG_GAIN: igain_q <= cfg_wdata_i[23:0];
        REG_INTEG_LIM:  ilim_q  <= cfg_wdata_i[22:0];
        REG_DRIVE_LIM:  dlim_q  <= cfg_wdata_i[14:0];
        REG_ANGLE_STEP: step_q  <= cfg_wdata_i[15:0];
        REG_PWM_PERIOD: per_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ca_q    <= ca_d;
    cb_q    <= cb_d;
    vdc_q   <= vdc_d;
    theta_q <= theta_d;
    s_q     <= s_d;
    c_q     <= c_d;
    ia_q    <= ia_d;
    ib_q    <= ib_d;
    beta_q  <= beta_d;
    id_q    <= id_d;
    iq_q    <= iq_d;
    vd_q    <= vd_d;
    vq_q    <= vq_d;
    acc_q   <= acc_d;
    va_q    <= va_d;
    vb_q    <= vb_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    pc_q    <= pc_d;
    mm_q    <= mm_d;
    ph_q    <= ph_d;
    duty_q  <= duty_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- src/focctl_checker.sv -----
// Port-level checks for the open-loop FOC current controller.
// Bound to the top level; sees only its handshake ports.
module focctl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // A pending result stays offered until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word withdrawn before it was taken");

  // An accepted word keeps the input closed while the angle is looked up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened too soon after a word was accepted");

  // A new result only appears at the end of a computation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

  // Returning to idle always comes with a result on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("block went idle without offering a result");

endmodule

bind foc_open_loop_current_controller focctl_checker u_focctl_checker (.*);

// ----- tb/sv/foc_open_loop_current_controller_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for foc_open_loop_current_controller.
// Drives current samples over the stream port, predicts each result in place and checks it.
// Depends on focctl_pkg and the controller RTL only.
module foc_open_loop_current_controller_tb;
  import focctl_pkg::*;

  localparam int unsigned IDLE_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned ANGLE_DROP = 16 - SINE_TABLE_BITS;

  typedef struct packed {
    logic [15:0] angle_used;
    logic [15:0] voltage_q;
    logic [15:0] voltage_d;
    logic [15:0] current_q;
    logic [15:0] current_d;
    logic [15:0] duty_c;
    logic [15:0] duty_b;
    logic [15:0] duty_a;
  } foc_result_t;

  // One directed row: the sample, the period to run it at, and what can be pinned by eye.
  typedef struct {
    logic [11:0] code_a;
    logic [11:0] code_b;
    logic [14:0] vbus;
    logic [15:0] period;
    bit          pin_angle;
    logic [15:0] angle;
    bit          pin_zero_duty;
  } sample_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // phase_a_code[11:0], phase_b_code[23:12], bus_voltage[38:24], zero pad [39]
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // duty_a, duty_b, duty_c, current_d, current_q, voltage_d, voltage_q, angle_used
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  foc_open_loop_current_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Controller settings and loop state as the predictor sees them.
  longint      set_d_target, set_q_target, set_step;
  longint      set_kp, set_ki, set_ilim, set_vlim, set_period;
  longint      integ_d, integ_q;
  logic [15:0] rotor_angle;

  foc_result_t expected_results[$];
  bit          failed;
  int unsigned burst_left, gap_left;
  int unsigned holdoff_req, holdoff_ack;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Rounds half up, then floors by 2^s.
  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Ninth-order odd polynomial over a quarter wave, x in 0..16384, Q15 out.
  function automatic longint quarter_wave(input longint x);
    longint zz, zsq, acc, res;
    zz  = x <<< 16;
    zsq = (zz * zz) >>> 30;
    acc = 172272;
    acc = 5026995 - ((acc * zsq) >>> 30);
    acc = 85569306 - ((acc * zsq) >>> 30);
    acc = 693598670 - ((acc * zsq) >>> 30);
    acc = 1686629713 - ((acc * zsq) >>> 30);
    res = (((acc * zz) >>> 30) + 16384) >>> 15;
    return (res > 32767) ? 32767 : res;
  endfunction

  function automatic longint sine_of(input logic [15:0] ang);
    logic [1:0]  quadrant;
    longint      frac;
    quadrant = ang[15:14];
    frac     = longint'(ang[13:0]);
    if (quadrant[0]) begin
      frac = 16384 - frac;
    end
    return quadrant[1] ? -quarter_wave(frac) : quarter_wave(frac);
  endfunction

  // One PI axis: updates its integrator and returns the limited voltage.
  function automatic longint pi_step(input longint target, input longint meas,
                                     inout longint integ);
    longint err, lim, acc;
    err   = target - meas;
    lim   = set_ilim <<< 8;
    acc   = clip(integ + round_shift(err * set_ki, 13), -lim, lim);
    integ = acc;
    return clip(round_shift(err * set_kp + 2 * acc, 9), -set_vlim, set_vlim);
  endfunction

  function automatic logic [15:0] duty_for(input longint v, input longint mm,
                                          input longint vdc);
    longint num, q;
    num = set_period * (65536 * vdc + 2 * v - mm);
    if (num <= 0) begin
      return 16'd0;
    end
    q = num / (131072 * vdc);
    return (q > set_period) ? set_period[15:0] : q[15:0];
  endfunction

  // Works out the result of one accepted sample and advances the loop state.
  function automatic foc_result_t control_step(input logic [39:0] word);
    foc_result_t r;
    longint vdc, ia, ib, beta, s, c, id, iq, vd, vq, va, vb, pa, pb, pc, mx, mn;
    logic [15:0] table_angle;
    vdc = longint'(word[38:24]);
    if (vdc == 0) begin
      vdc = 1;
    end
    ia   = (longint'(word[11:0]) * 40960 + 4095) / 8190 - 10240;
    ib   = (longint'(word[23:12]) * 40960 + 4095) / 8190 - 10240;
    beta = round_shift((ia + 2 * ib) * 37837, 16);
    table_angle = (rotor_angle >> ANGLE_DROP) << ANGLE_DROP;
    s  = sine_of(table_angle);
    c  = sine_of(table_angle + 16'h4000);
    id = clip(round_shift(ia * c + beta * s, 15), -32768, 32767);
    iq = clip(round_shift(-ia * s + beta * c, 15), -32768, 32767);
    vd = pi_step(set_d_target, id, integ_d);
    vq = pi_step(set_q_target, iq, integ_q);
    va = round_shift(vd * c - vq * s, 15);
    vb = round_shift(vd * s + vq * c, 15);
    pa = va * 65536;
    pb = -va * 32768 + vb * 56756;
    pc = -va * 32768 - vb * 56756;
    mx = (pa > pb) ? pa : pb;
    mx = (pc > mx) ? pc : mx;
    mn = (pa < pb) ? pa : pb;
    mn = (pc < mn) ? pc : mn;
    r.duty_a     = duty_for(pa, mx + mn, vdc);
    r.duty_b     = duty_for(pb, mx + mn, vdc);
    r.duty_c     = duty_for(pc, mx + mn, vdc);
    r.current_d  = id[15:0];
    r.current_q  = iq[15:0];
    r.voltage_d  = vd[15:0];
    r.voltage_q  = vq[15:0];
    r.angle_used = rotor_angle;
    rotor_angle  = rotor_angle + set_step[15:0];
    return r;
  endfunction

  // Waits for the pipeline to empty so that a register may be written.
  task automatic wait_idle();
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (130) @(posedge clk_i);
  endtask

  // Writes one register and drops the write enable again before returning, so writes never share an edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_D_TARGET:   set_d_target = longint'($signed(val[15:0]));
      REG_Q_TARGET:   set_q_target = longint'($signed(val[15:0]));
      REG_PROP_GAIN:  set_kp       = longint'(val[15:0]);
      REG_INTEG_GAIN: set_ki       = longint'(val[23:0]);
      REG_INTEG_LIM:  set_ilim     = longint'(val[22:0]);
      REG_DRIVE_LIM:  set_vlim     = longint'(val[14:0]);
      REG_ANGLE_STEP: set_step     = longint'($signed(val[15:0]));
      REG_PWM_PERIOD: set_period   = longint'(val[15:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one word in bursts with random gaps; the expectation is queued on acceptance.
  task automatic send_word(input logic [39:0] word, output foc_result_t exp_r);
    if (gap_left != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do begin
      @(posedge clk_i);
    end while (!(s_axis_tvalid && s_axis_tready));
    exp_r = control_step(word);
    expected_results.push_back(exp_r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [39:0] random_sample();
    logic [11:0] a, b;
    logic [14:0] v;
    if ($urandom_range(0, 9) < 7) begin
      a = 12'($urandom_range(1748, 2348));
      b = 12'($urandom_range(1748, 2348));
    end else begin
      a = 12'($urandom);
      b = 12'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       v = 15'($urandom_range(1, 200));
      1:       v = 15'($urandom);
      default: v = 15'($urandom_range(12000, 32767));
    endcase
    return {1'b0, v, b, a};
  endfunction

  // Picks a register value: an extreme now and then, random otherwise.
  function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_DATA_W-1:0] lo,
                                                      input logic [CFG_DATA_W-1:0] hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return lo + CFG_DATA_W'($urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  // Receiver: stall pattern of its own, one long hold-off on request, result checking.
  int unsigned pattern_mode, pattern_left, holdoff_left, idle_cycles;
  foc_result_t got, want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pattern_mode  = 0;
      pattern_left  = 0;
      holdoff_left  = 0;
      idle_cycles   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (got.duty_a !== want.duty_a)
            $display("%0t: duty_a exp %0d got %0d", $time, want.duty_a, got.duty_a);
          if (got.duty_b !== want.duty_b)
            $display("%0t: duty_b exp %0d got %0d", $time, want.duty_b, got.duty_b);
          if (got.duty_c !== want.duty_c)
            $display("%0t: duty_c exp %0d got %0d", $time, want.duty_c, got.duty_c);
          if (got.current_d !== want.current_d)
            $display("%0t: current_d exp %0d got %0d", $time,
                     $signed(want.current_d), $signed(got.current_d));
          if (got.current_q !== want.current_q)
            $display("%0t: current_q exp %0d got %0d", $time,
                     $signed(want.current_q), $signed(got.current_q));
          if (got.voltage_d !== want.voltage_d)
            $display("%0t: voltage_d exp %0d got %0d", $time,
                     $signed(want.voltage_d), $signed(got.voltage_d));
          if (got.voltage_q !== want.voltage_q)
            $display("%0t: voltage_q exp %0d got %0d", $time,
                     $signed(want.voltage_q), $signed(got.voltage_q));
          if (got.angle_used !== want.angle_used)
            $display("%0t: angle_used exp %0d got %0d", $time, want.angle_used,
                     got.angle_used);
          if (got !== want) begin
            failed = 1'b1;
          end
        end
      end
      // Watchdog on cycles in which neither side moves a word.
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else if (expected_results.size() != 0 || s_axis_tvalid) begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
      if (holdoff_req != holdoff_ack) begin
        holdoff_ack  = holdoff_req;
        holdoff_left = 700;
      end
      if (pattern_left == 0) begin
        pattern_mode = $urandom_range(0, 2);
        pattern_left = $urandom_range(20, 400);
      end else begin
        pattern_left--;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (pattern_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  sample_row_t directed_rows[] = '{
    '{12'd2048, 12'd2048, 15'd24576, 16'd1000, 1'b1, 16'd0, 1'b0},
    '{12'd0,    12'd0,    15'd24576, 16'd1000, 1'b1, 16'd5, 1'b0},
    '{12'd4095, 12'd4095, 15'd24576, 16'd1000, 1'b1, 16'd10, 1'b0},
    '{12'd0,    12'd4095, 15'd24576, 16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd4095, 12'd0,    15'd24576, 16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd2047, 12'd2049, 15'd0,     16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd2100, 12'd1990, 15'd1,     16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd2048, 12'd2048, 15'd32767, 16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd3000, 12'd1000, 15'd200,   16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd1,    12'd4094, 15'd16384, 16'd1000, 1'b0, 16'd0, 1'b0},
    '{12'd2048, 12'd2048, 15'd24576, 16'd0,    1'b0, 16'd0, 1'b1},
    '{12'd0,    12'd4095, 15'd1,     16'd0,    1'b0, 16'd0, 1'b1},
    '{12'd4095, 12'd0,    15'd32767, 16'd0,    1'b0, 16'd0, 1'b1},
    '{12'd2048, 12'd2048, 15'd24576, 16'd65535, 1'b0, 16'd0, 1'b0},
    '{12'd0,    12'd0,    15'd1,     16'd65535, 1'b0, 16'd0, 1'b0},
    '{12'd4095, 12'd4095, 15'd32767, 16'd65535, 1'b0, 16'd0, 1'b0},
    '{12'd2500, 12'd1600, 15'd12000, 16'd65535, 1'b0, 16'd0, 1'b0}
  };

  initial begin
    foc_result_t pred;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    failed        = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    holdoff_req   = 0;
    holdoff_ack   = 0;
    set_d_target  = 0;
    set_q_target  = 512;
    set_kp        = 128;
    set_ki        = 2621;
    set_ilim      = 256000;
    set_vlim      = 6144;
    set_step      = 5;
    set_period    = 1000;
    integ_d       = 0;
    integ_q       = 0;
    rotor_angle   = '0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset settings, then at zero and full period.
    foreach (directed_rows[i]) begin
      if (longint'(directed_rows[i].period) != set_period) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        cfg_write(REG_PWM_PERIOD, CFG_DATA_W'(directed_rows[i].period));
      end
      send_word({1'b0, directed_rows[i].vbus, directed_rows[i].code_b,
                 directed_rows[i].code_a}, pred);
      if (directed_rows[i].pin_angle && pred.angle_used !== directed_rows[i].angle) begin
        $display("%0t: row %0d angle exp %0d pred %0d", $time, i,
                 directed_rows[i].angle, pred.angle_used);
        failed = 1'b1;
      end
      if (directed_rows[i].pin_zero_duty &&
          (pred.duty_a | pred.duty_b | pred.duty_c) !== 16'd0) begin
        $display("%0t: row %0d duties exp 0 pred %0d %0d %0d", $time, i,
                 pred.duty_a, pred.duty_b, pred.duty_c);
        failed = 1'b1;
      end
    end

    // Random phases, each under a fresh set of register values.
    for (int ph = 0; ph < 9; ph++) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      cfg_write(REG_D_TARGET,   pick_value(24'hFF8000 & 24'h00FFFF, 24'h007FFF) ^
                                (($urandom_range(0, 1) != 0) ? 24'h008000 : 24'h0));
      cfg_write(REG_Q_TARGET,   CFG_DATA_W'($urandom_range(0, 65535)));
      cfg_write(REG_PROP_GAIN,  pick_value(24'd0, 24'd65535));
      cfg_write(REG_INTEG_GAIN, pick_value(24'd0, 24'hFFFFFF));
      cfg_write(REG_INTEG_LIM,  pick_value(24'd0, 24'h7FFFFF));
      cfg_write(REG_DRIVE_LIM,  pick_value(24'd0, 24'h7FFF));
      cfg_write(REG_ANGLE_STEP, pick_value(24'd0, 24'hFFFF));
      cfg_write(REG_PWM_PERIOD, pick_value(24'd1, 24'hFFFF));
      if (ph == 1 || ph == 6) begin
        holdoff_req++;
      end
      for (int n = 0; n < 105; n++) begin
        send_word(random_sample(), pred);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
